// ===== design/i2cm_pkg.sv =====
`timescale 1ns / 1ps
package i2cm_pkg;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_RSVD  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE, PH_TX_LO, PH_TX_HI, PH_ACK_LO, PH_ACK_HI, PH_RX_LO, PH_RX_HI,
        PH_MACK_LO, PH_MACK_HI, PH_RS_A, PH_RS_B, PH_RS_C,
        PH_STOP_A, PH_STOP_B, PH_STOP_C
    } phase_t;

    typedef enum logic [2:0] {
        ST_ADDRW, ST_REG, ST_DATA, ST_CRC, ST_ADDRR, ST_RXDATA, ST_RXCRC
    } stage_t;

    typedef enum logic [1:0] {
        REG_SLAVE_ADDR = 2'd0,
        REG_ACK_TMO    = 2'd1,
        REG_CRC_POLY   = 2'd2
    } reg_idx_t;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_NACK = 2'd1;
    localparam logic [1:0] STATUS_CRC  = 2'd2;

    localparam logic [6:0] SLAVE_ADDR_RST = 7'd8;
    localparam logic [7:0] ACK_TMO_RST    = 8'd250;
    localparam logic [7:0] CRC_POLY_RST   = 8'h07;

    typedef struct packed {
        logic [6:0] slave_address;
        logic [7:0] ack_timeout;
        logic [7:0] crc_poly;
    } cfg_t;

    // CRC-8, MSB first, implicit x^8 term
    function automatic logic [7:0] crc8(input logic [7:0] crc_in,
                                        input logic [7:0] data,
                                        input logic [7:0] poly);
        logic [7:0] c;
        logic       fb;
        c = crc_in;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[7] ^ data[i];
            c  = {c[6:0], 1'b0};
            if (fb)
            begin
                c = c ^ poly;
            end
        end
        return c;
    endfunction

endpackage

// ===== design/i2cm_if.sv =====
`timescale 1ns / 1ps
interface i2cm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [5:0] read_count;
    logic       sda_in;

    modport source (output valid, kind, reg_addr, write_data, read_count, sda_in,
                    input ready);
    modport sink   (input valid, kind, reg_addr, write_data, read_count, sda_in,
                    output ready);
endinterface

interface i2cm_rsp_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       byte_valid;
    logic [7:0] read_byte;
    logic       byte_crc_bad;
    logic       last_byte;
    logic       done_res;
    logic [1:0] status;

    modport source (output valid, scl_level, sda_release, busy_res, byte_valid,
                    read_byte, byte_crc_bad, last_byte, done_res, status,
                    input ready);
    modport sink   (input valid, scl_level, sda_release, busy_res, byte_valid,
                    read_byte, byte_crc_bad, last_byte, done_res, status,
                    output ready);
endinterface

// ===== design/i2cm_regs.sv =====
`timescale 1ns / 1ps
module i2cm_regs (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    output i2cm_pkg::cfg_t  cfg
);
    import i2cm_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[3:2];
    assign cfg    = cfg_reg;

    // write registers on the access beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_address <= SLAVE_ADDR_RST;
            cfg_reg.ack_timeout   <= ACK_TMO_RST;
            cfg_reg.crc_poly      <= CRC_POLY_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_SLAVE_ADDR: cfg_reg.slave_address <= pwdata[6:0];
                REG_ACK_TMO:    cfg_reg.ack_timeout   <= pwdata[7:0];
                REG_CRC_POLY:   cfg_reg.crc_poly      <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            REG_SLAVE_ADDR: prdata = {25'd0, cfg_reg.slave_address};
            REG_ACK_TMO:    prdata = {24'd0, cfg_reg.ack_timeout};
            REG_CRC_POLY:   prdata = {24'd0, cfg_reg.crc_poly};
            default:        prdata = 32'd0;
        endcase
    end
endmodule

// ===== design/i2c_master_with_crc8.sv =====
`timescale 1ns / 1ps
// I2C master with CRC-8 byte protection.
// Channel req carries one beat per half-bit bus tick, or a start command
// (kind write or read) that also counts as the tick driving START. Channel
// rsp returns exactly one beat per req beat: SCL/SDA drive levels, busy,
// a received data byte with its CRC check, and done with status at the
// final STOP tick. Registers (APB): slave address, ACK timeout, CRC poly.
// The rsp beat is registered and valid in the cycle after its req beat is
// accepted. Throughput: one beat per cycle; the whole controller step for
// a beat (phase advance, shift, CRC byte update) is one pass of logic into
// the state and output registers. The output register lets a new req beat
// in while the previous rsp beat is taken in the same cycle; when rsp
// stalls, req.ready drops and the controller holds. Reset returns it to
// idle, clears its state, loads register defaults (addr 8, timeout 250, poly 7).
// Configuration is to be written only while the bus is idle.
module i2c_master_with_crc8 #(
    parameter int MAX_READ_BYTES = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    i2cm_req_if.sink     req,
    i2cm_rsp_if.source   rsp,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import i2cm_pkg::*;

    localparam logic [5:0] MAX_CNT = 6'(MAX_READ_BYTES);

    cfg_t cfg;

    i2cm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    phase_t     phase_reg,   phase_next;
    stage_t     stage_reg,   stage_next;
    logic [3:0] bitcnt_reg,  bitcnt_next;
    logic [7:0] shifter_reg, shifter_next;
    logic [7:0] crc_reg,     crc_next;
    logic [5:0] left_reg,    left_next;
    logic [7:0] wait_reg,    wait_next;
    logic       isrd_reg,    isrd_next;
    logic [7:0] haddr_reg,   haddr_next;
    logic [7:0] hdata_reg,   hdata_next;
    logic       crcbad_reg,  crcbad_next;
    logic       nack_reg,    nack_next;

    logic       ovalid_reg,  ovalid_next;
    logic       scl_reg, sda_reg, busy_reg, bv_reg, bad_reg, last_reg, done_reg;
    logic [7:0] rbyte_reg;
    logic [1:0] stat_reg;

    logic       scl, sdo, busy, bv, bad, last, done;
    logic [7:0] rb;
    logic [1:0] stat;

    logic       accept;
    logic [7:0] addr_w, addr_r;
    logic [7:0] crc_base, crc_data, crc_out;
    logic [7:0] rx_shift;
    logic [3:0] bit_inc;
    logic [7:0] wait_inc;
    logic [5:0] cnt;
    logic       mack_bit;
    kind_t      kind;

    assign req.ready = !ovalid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign kind      = kind_t'(req.kind);
    assign addr_w    = {cfg.slave_address, 1'b0};
    assign addr_r    = {cfg.slave_address, 1'b1};
    assign rx_shift  = {shifter_reg[6:0], req.sda_in};
    assign bit_inc   = bitcnt_reg + 4'd1;
    assign wait_inc  = wait_reg + 8'd1;
    assign mack_bit  = (stage_reg == ST_RXCRC) && (left_reg == 6'd0);

    // clamp read length
    always_comb
    begin
        cnt = req.read_count;
        if (cnt == 6'd0)
        begin
            cnt = 6'd1;
        end
        if (cnt > MAX_CNT)
        begin
            cnt = MAX_CNT;
        end
    end

    // pick the single CRC byte update this beat may need
    always_comb
    begin
        crc_base = crc_reg;
        crc_data = rx_shift;
        case (phase_reg)
            PH_IDLE:
            begin
                crc_base = 8'd0;
                crc_data = addr_w;
            end
            PH_ACK_HI:
                crc_data = (stage_reg == ST_ADDRW) ? haddr_reg : hdata_reg;
            PH_RS_C:
            begin
                crc_base = 8'd0;
                crc_data = addr_r;
            end
            default: ;
        endcase
    end

    assign crc_out = crc8(crc_base, crc_data, cfg.crc_poly);

    // controller step for one beat
    always_comb
    begin
        phase_next   = phase_reg;
        stage_next   = stage_reg;
        bitcnt_next  = bitcnt_reg;
        shifter_next = shifter_reg;
        crc_next     = crc_reg;
        left_next    = left_reg;
        wait_next    = wait_reg;
        isrd_next    = isrd_reg;
        haddr_next   = haddr_reg;
        hdata_next   = hdata_reg;
        crcbad_next  = crcbad_reg;
        nack_next    = nack_reg;
        scl  = 1'b1;
        sdo  = 1'b1;
        busy = 1'b1;
        bv   = 1'b0;
        rb   = 8'd0;
        bad  = 1'b0;
        last = 1'b0;
        done = 1'b0;
        stat = STATUS_OK;

        unique case (phase_reg)
            PH_IDLE:
            begin
                busy = 1'b0;
                if (kind == KIND_WRITE || kind == KIND_READ)
                begin
                    busy         = 1'b1;
                    sdo          = 1'b0;
                    haddr_next   = req.reg_addr;
                    hdata_next   = req.write_data;
                    left_next    = cnt;
                    isrd_next    = (kind == KIND_READ);
                    crcbad_next  = 1'b0;
                    nack_next    = 1'b0;
                    wait_next    = 8'd0;
                    stage_next   = ST_ADDRW;
                    shifter_next = addr_w;
                    bitcnt_next  = 4'd0;
                    crc_next     = crc_out;
                    phase_next   = PH_TX_LO;
                end
            end
            PH_TX_LO:
            begin
                scl        = 1'b0;
                sdo        = shifter_reg[7];
                phase_next = PH_TX_HI;
            end
            PH_TX_HI:
            begin
                sdo          = shifter_reg[7];
                shifter_next = {shifter_reg[6:0], 1'b0};
                if (bit_inc >= 4'd8)
                begin
                    bitcnt_next = 4'd0;
                    wait_next   = 8'd0;
                    phase_next  = PH_ACK_LO;
                end
                else
                begin
                    bitcnt_next = bit_inc;
                    phase_next  = PH_TX_LO;
                end
            end
            PH_ACK_LO:
            begin
                scl        = 1'b0;
                phase_next = PH_ACK_HI;
            end
            PH_ACK_HI:
            begin
                if (req.sda_in)
                begin
                    wait_next = wait_inc;
                    if (wait_inc >= cfg.ack_timeout)
                    begin
                        nack_next  = 1'b1;
                        phase_next = PH_STOP_A;
                    end
                end
                else
                begin
                    case (stage_reg)
                        ST_ADDRW:
                        begin
                            stage_next   = ST_REG;
                            shifter_next = haddr_reg;
                            bitcnt_next  = 4'd0;
                            crc_next     = crc_out;
                            phase_next   = PH_TX_LO;
                        end
                        ST_REG:
                        begin
                            if (isrd_reg)
                            begin
                                phase_next = PH_RS_A;
                            end
                            else
                            begin
                                stage_next   = ST_DATA;
                                shifter_next = hdata_reg;
                                bitcnt_next  = 4'd0;
                                crc_next     = crc_out;
                                phase_next   = PH_TX_LO;
                            end
                        end
                        ST_DATA:
                        begin
                            stage_next   = ST_CRC;
                            shifter_next = crc_reg;
                            bitcnt_next  = 4'd0;
                            phase_next   = PH_TX_LO;
                        end
                        ST_ADDRR:
                        begin
                            stage_next   = ST_RXDATA;
                            bitcnt_next  = 4'd0;
                            shifter_next = 8'd0;
                            phase_next   = PH_RX_LO;
                        end
                        default: phase_next = PH_STOP_A;
                    endcase
                end
            end
            PH_RX_LO:
            begin
                scl        = 1'b0;
                phase_next = PH_RX_HI;
            end
            PH_RX_HI:
            begin
                shifter_next = rx_shift;
                bitcnt_next  = bit_inc;
                phase_next   = PH_RX_LO;
                if (bit_inc >= 4'd8)
                begin
                    bitcnt_next = 4'd0;
                    phase_next  = PH_MACK_LO;
                    if (stage_reg == ST_RXDATA)
                    begin
                        hdata_next = rx_shift;
                        crc_next   = crc_out;
                    end
                    else
                    begin
                        bv   = 1'b1;
                        rb   = hdata_reg;
                        bad  = (rx_shift != crc_reg);
                        last = (left_reg <= 6'd1);
                        if (bad)
                        begin
                            crcbad_next = 1'b1;
                        end
                        left_next = (left_reg != 6'd0) ? left_reg - 6'd1 : 6'd0;
                        crc_next  = 8'd0;
                    end
                end
            end
            PH_MACK_LO:
            begin
                scl        = 1'b0;
                sdo        = mack_bit;
                phase_next = PH_MACK_HI;
            end
            PH_MACK_HI:
            begin
                sdo          = mack_bit;
                shifter_next = 8'd0;
                if (stage_reg == ST_RXDATA)
                begin
                    stage_next = ST_RXCRC;
                    phase_next = PH_RX_LO;
                end
                else if (mack_bit)
                begin
                    phase_next = PH_STOP_A;
                end
                else
                begin
                    stage_next = ST_RXDATA;
                    phase_next = PH_RX_LO;
                end
            end
            PH_RS_A:
            begin
                scl        = 1'b0;
                phase_next = PH_RS_B;
            end
            PH_RS_B:
                phase_next = PH_RS_C;
            PH_RS_C:
            begin
                sdo          = 1'b0;
                stage_next   = ST_ADDRR;
                shifter_next = addr_r;
                bitcnt_next  = 4'd0;
                crc_next     = crc_out;
                phase_next   = PH_TX_LO;
            end
            PH_STOP_A:
            begin
                scl        = 1'b0;
                sdo        = 1'b0;
                phase_next = PH_STOP_B;
            end
            PH_STOP_B:
            begin
                sdo        = 1'b0;
                phase_next = PH_STOP_C;
            end
            PH_STOP_C:
            begin
                done       = 1'b1;
                stat       = nack_reg ? STATUS_NACK :
                             (crcbad_reg ? STATUS_CRC : STATUS_OK);
                phase_next = PH_IDLE;
            end
            default:
            begin
                busy       = 1'b0;
                phase_next = PH_IDLE;
            end
        endcase
    end

    // output beat valid
    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (accept)
        begin
            ovalid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    // controller state, advance on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            stage_reg   <= ST_ADDRW;
            bitcnt_reg  <= 4'd0;
            shifter_reg <= 8'd0;
            crc_reg     <= 8'd0;
            left_reg    <= 6'd0;
            wait_reg    <= 8'd0;
            isrd_reg    <= 1'b0;
            haddr_reg   <= 8'd0;
            hdata_reg   <= 8'd0;
            crcbad_reg  <= 1'b0;
            nack_reg    <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            if (accept)
            begin
                phase_reg   <= phase_next;
                stage_reg   <= stage_next;
                bitcnt_reg  <= bitcnt_next;
                shifter_reg <= shifter_next;
                crc_reg     <= crc_next;
                left_reg    <= left_next;
                wait_reg    <= wait_next;
                isrd_reg    <= isrd_next;
                haddr_reg   <= haddr_next;
                hdata_reg   <= hdata_next;
                crcbad_reg  <= crcbad_next;
                nack_reg    <= nack_next;
            end
        end
    end

    // result payload, load on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            scl_reg   <= scl;
            sda_reg   <= sdo;
            busy_reg  <= busy;
            bv_reg    <= bv;
            rbyte_reg <= rb;
            bad_reg   <= bad;
            last_reg  <= last;
            done_reg  <= done;
            stat_reg  <= stat;
        end
    end

    assign rsp.valid        = ovalid_reg;
    assign rsp.scl_level    = scl_reg;
    assign rsp.sda_release  = sda_reg;
    assign rsp.busy_res     = busy_reg;
    assign rsp.byte_valid   = bv_reg;
    assign rsp.read_byte    = rbyte_reg;
    assign rsp.byte_crc_bad = bad_reg;
    assign rsp.last_byte    = last_reg;
    assign rsp.done_res     = done_reg;
    assign rsp.status       = stat_reg;

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.done_res |-> rsp.busy_res)
        else $error("done beat without busy");

    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.done_res |-> rsp.status == STATUS_OK)
        else $error("status reported outside done beat");

    a_byte_scl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.byte_valid |-> rsp.scl_level && rsp.busy_res)
        else $error("received byte outside SCL high tick");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE && !accept |=> phase_reg == PH_IDLE)
        else $error("controller left idle without a beat");
endmodule
